[rtl/core/ttr_pkg.sv]
package ttr_pkg;

  localparam int unsigned TagW         = 6;
  localparam int unsigned DataW        = 32;
  localparam int unsigned RingDepthDef = 64;
  localparam int unsigned WordBitsDef  = 32;

  typedef enum logic [1:0] {
    CMD_DISPATCH = 2'd0,
    CMD_FETCH    = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_CONSUME  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOT_DONE = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [TagW-1:0]  tag;
    logic [DataW-1:0] task_arg;
    logic [DataW-1:0] completion_value;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [TagW-1:0]  tag_out;
    logic [DataW-1:0] arg_out;
    logic [DataW-1:0] value_out;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    dispatch;
    logic    fetch;
    logic    complete;
    logic    cons_rd;
    logic    fetch_cap;
    logic    cons_commit;
    logic    res_clr;
    status_e res_status;
    logic    out_load;
    logic    walk_rd;
    logic    walk_adv;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic can_complete;
    logic live_hit;
    logic done_rd;
    logic walk_end;
    logic walk_ok;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/task_tag_ring_in_order_reclaim.sv]
// flow: a command is latched and executed; a fetch from a non-empty ring and a consume inside
//   the live window add a registered read, then the reply waits for a free output register
// handshake: in_stall is held outside idle, so a new item is taken only after the reply is
//   loaded and, after a successful consume, the walk over the oldest reclaimable slots ends
// reset: asynchronous active low, clears the three ring pointers and the output valid;
//   slot memories are not cleared: arg and flags are rewritten on dispatch, value on complete
module task_tag_ring_in_order_reclaim #(
  parameter int unsigned RING_DEPTH = ttr_pkg::RingDepthDef,
  parameter int unsigned WORD_BITS  = ttr_pkg::WordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ttr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ttr_pkg::out_item_t out_item_o
);

  import ttr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ttr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ttr_dp #(
    .RING_DEPTH (RING_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

[rtl/core/ttr_ram.sv]
module ttr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ttr_ctrl.sv]
module ttr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ttr_pkg::sts_t sts_i,
  output ttr_pkg::ctl_t ctl_o
);

  import ttr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EXEC     = 7'b0000010,
    S_FETCH_RD = 7'b0000100,
    S_CONS_RD  = 7'b0001000,
    S_PUT      = 7'b0010000,
    S_WALK_RD  = 7'b0100000,
    S_WALK_CHK = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   walk_q, walk_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    walk_d  = walk_q;
    ctl_o   = '0;
    ctl_o.res_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.cmd)
          CMD_DISPATCH: begin
            ctl_o.res_clr = 1'b1;
            if (sts_i.full) begin
              ctl_o.res_status = ST_FULL;
            end else begin
              ctl_o.dispatch = 1'b1;
            end
            state_d = S_PUT;
          end
          CMD_FETCH: begin
            ctl_o.res_clr = 1'b1;
            if (sts_i.empty) begin
              ctl_o.res_status = ST_EMPTY;
              state_d          = S_PUT;
            end else begin
              ctl_o.fetch = 1'b1;
              state_d     = S_FETCH_RD;
            end
          end
          CMD_COMPLETE: begin
            // complete of a tag outside the issued window is dropped
            ctl_o.res_clr  = 1'b1;
            ctl_o.complete = sts_i.can_complete;
            state_d        = S_PUT;
          end
          CMD_CONSUME: begin
            if (sts_i.live_hit) begin
              ctl_o.cons_rd = 1'b1;
              state_d       = S_CONS_RD;
            end else begin
              ctl_o.res_clr    = 1'b1;
              ctl_o.res_status = ST_NOT_DONE;
              state_d          = S_PUT;
            end
          end
          default: state_d = S_PUT;
        endcase
      end
      S_FETCH_RD: begin
        ctl_o.fetch_cap = 1'b1;
        state_d         = S_PUT;
      end
      S_CONS_RD: begin
        ctl_o.res_clr = 1'b1;
        if (sts_i.done_rd) begin
          ctl_o.cons_commit = 1'b1;
          walk_d            = 1'b1;
        end else begin
          ctl_o.res_status = ST_NOT_DONE;
        end
        state_d = S_PUT;
      end
      S_PUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          walk_d         = 1'b0;
          state_d        = walk_q ? S_WALK_RD : S_IDLE;
        end
      end
      S_WALK_RD: begin
        if (sts_i.walk_end) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.walk_rd = 1'b1;
          state_d       = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        // oldest slot retires only once both done and consumed
        if (sts_i.walk_ok) begin
          ctl_o.walk_adv = 1'b1;
          state_d        = S_WALK_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
    end
  end

endmodule

[rtl/core/ttr_dp.sv]
module ttr_dp #(
  parameter int unsigned RING_DEPTH = ttr_pkg::RingDepthDef,
  parameter int unsigned WORD_BITS  = ttr_pkg::WordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttr_pkg::in_item_t  in_item_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output ttr_pkg::out_item_t out_item_o,
  input  ttr_pkg::ctl_t      ctl_i,
  output ttr_pkg::sts_t      sts_o
);

  import ttr_pkg::*;

  localparam int unsigned SlotW = $clog2(RING_DEPTH);
  localparam int unsigned PtrW  = SlotW + 1;

  // latched command
  cmd_e             cmd_q;
  logic [SlotW-1:0] slot_q;
  logic [WORD_BITS-1:0] arg_q;
  logic [WORD_BITS-1:0] val_q;

  logic [PtrW-1:0] alloc_q, issue_q, recl_q;

  out_item_t res_q, res_d;
  out_item_t out_q;
  logic      out_valid_q;

  // width adapters between fixed port fields and ring sizes
  logic [SlotW+TagW-1:0]      tag_ext;
  logic [WORD_BITS+DataW-1:0] arg_ext, val_ext;
  logic [SlotW+TagW-1:0]      alloc_tag_ext, issue_tag_ext;
  logic [WORD_BITS+DataW-1:0] arg_rd_ext, val_rd_ext;

  logic [SlotW-1:0] alloc_slot, issue_slot, recl_slot;
  logic [PtrW-1:0]  live, issued;
  logic [SlotW-1:0] off;

  logic [WORD_BITS-1:0] arg_rd, val_rd;
  logic                 done_rd, cons_rd;

  logic             flag_we;
  logic [SlotW-1:0] flag_waddr;
  logic [SlotW-1:0] done_raddr;

  assign tag_ext = {{SlotW{1'b0}}, in_item_i.tag};
  assign arg_ext = {{WORD_BITS{1'b0}}, in_item_i.task_arg};
  assign val_ext = {{WORD_BITS{1'b0}}, in_item_i.completion_value};

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= in_item_i.cmd;
      slot_q <= tag_ext[SlotW-1:0];
      arg_q  <= arg_ext[WORD_BITS-1:0];
      val_q  <= val_ext[WORD_BITS-1:0];
    end
  end

  assign alloc_slot = alloc_q[SlotW-1:0];
  assign issue_slot = issue_q[SlotW-1:0];
  assign recl_slot  = recl_q[SlotW-1:0];

  assign live   = alloc_q - recl_q;
  assign issued = issue_q - recl_q;
  assign off    = slot_q - recl_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      issue_q <= '0;
      recl_q  <= '0;
    end else begin
      if (ctl_i.dispatch) alloc_q <= alloc_q + PtrW'(1);
      if (ctl_i.fetch)    issue_q <= issue_q + PtrW'(1);
      if (ctl_i.walk_adv) recl_q  <= recl_q + PtrW'(1);
    end
  end

  ttr_ram #(.Width(WORD_BITS), .Depth(RING_DEPTH)) u_arg_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.dispatch),
    .waddr_i (alloc_slot),
    .wdata_i (arg_q),
    .re_i    (ctl_i.fetch),
    .raddr_i (issue_slot),
    .rdata_o (arg_rd)
  );

  ttr_ram #(.Width(WORD_BITS), .Depth(RING_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.complete),
    .waddr_i (slot_q),
    .wdata_i (val_q),
    .re_i    (ctl_i.cons_rd),
    .raddr_i (slot_q),
    .rdata_o (val_rd)
  );

  // flags of a slot are cleared on dispatch, so they need no reset
  assign flag_waddr = ctl_i.dispatch ? alloc_slot : slot_q;
  assign flag_we    = ctl_i.dispatch | ctl_i.complete;
  assign done_raddr = ctl_i.walk_rd ? recl_slot : slot_q;

  ttr_ram #(.Width(1), .Depth(RING_DEPTH)) u_done_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (ctl_i.complete),
    .re_i    (ctl_i.cons_rd | ctl_i.walk_rd),
    .raddr_i (done_raddr),
    .rdata_o (done_rd)
  );

  ttr_ram #(.Width(1), .Depth(RING_DEPTH)) u_cons_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.dispatch | ctl_i.cons_commit),
    .waddr_i (flag_waddr),
    .wdata_i (ctl_i.cons_commit),
    .re_i    (ctl_i.walk_rd),
    .raddr_i (recl_slot),
    .rdata_o (cons_rd)
  );

  assign alloc_tag_ext = {{TagW{1'b0}}, alloc_slot};
  assign issue_tag_ext = {{TagW{1'b0}}, issue_slot};
  assign arg_rd_ext    = {{DataW{1'b0}}, arg_rd};
  assign val_rd_ext    = {{DataW{1'b0}}, val_rd};

  always_comb begin
    res_d = res_q;
    if (ctl_i.res_clr) begin
      res_d        = '0;
      res_d.status = ctl_i.res_status;
    end
    if (ctl_i.dispatch)    res_d.tag_out   = alloc_tag_ext[TagW-1:0];
    if (ctl_i.fetch)       res_d.tag_out   = issue_tag_ext[TagW-1:0];
    if (ctl_i.fetch_cap)   res_d.arg_out   = arg_rd_ext[DataW-1:0];
    if (ctl_i.cons_commit) res_d.value_out = val_rd_ext[DataW-1:0];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ctl_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.cmd          = cmd_q;
  assign sts_o.full         = live[SlotW];
  assign sts_o.empty        = (issue_q == alloc_q);
  assign sts_o.can_complete = ({1'b0, off} < issued);
  assign sts_o.live_hit     = ({1'b0, off} < live);
  assign sts_o.done_rd      = done_rd;
  assign sts_o.walk_end     = (recl_q == alloc_q);
  assign sts_o.walk_ok      = done_rd & cons_rd;
  assign sts_o.out_free     = ~out_valid_q | ~out_stall_i;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import ttr_pkg::*;

  localparam int unsigned Depth = RingDepthDef;

  class task_ring_shadow;
    bit [DataW-1:0] arg_mem[Depth];
    bit [DataW-1:0] val_mem[Depth];
    bit             done_q[Depth];
    bit             consumed_q[Depth];
    bit [TagW:0]    alloc_p;
    bit [TagW:0]    issue_p;
    bit [TagW:0]    reclaim_p;
    out_item_t      replies_due[$];
    int             errors;
    int             n_items;
    int             n_checked;
    int             n_full;
    int             n_empty;
    int             n_not_done;

    function int pending_count();
      return replies_due.size();
    endfunction

    // tag among the issued live slots, optionally only done ones; a random tag if none fits
    function bit [TagW-1:0] pick_tag(bit need_done);
      bit [TagW-1:0] cand[$];
      bit [TagW-1:0] slot;
      bit [TagW:0]   issued;
      issued = issue_p - reclaim_p;
      for (int k = 0; k < issued; k++) begin
        slot = reclaim_p[TagW-1:0] + TagW'(k);
        if (!need_done || done_q[slot]) cand.push_back(slot);
      end
      if (cand.size() == 0) return TagW'($urandom);
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function void note_command(in_item_t it);
      out_item_t     r;
      bit [TagW:0]   live;
      bit [TagW:0]   issued;
      bit [TagW-1:0] s;
      bit [TagW-1:0] off;
      bit [TagW-1:0] a;
      r        = '0;
      r.status = ST_OK;
      s        = it.tag;
      live     = alloc_p - reclaim_p;
      issued   = issue_p - reclaim_p;
      off      = s - reclaim_p[TagW-1:0];
      n_items++;
      case (it.cmd)
        CMD_DISPATCH: begin
          if (live >= Depth) begin
            r.status = ST_FULL;
          end else begin
            a             = alloc_p[TagW-1:0];
            arg_mem[a]    = it.task_arg;
            done_q[a]     = 1'b0;
            consumed_q[a] = 1'b0;
            r.tag_out     = a;
            alloc_p++;
          end
        end
        CMD_FETCH: begin
          if (issue_p == alloc_p) begin
            r.status = ST_EMPTY;
          end else begin
            a         = issue_p[TagW-1:0];
            r.tag_out = a;
            r.arg_out = arg_mem[a];
            issue_p++;
          end
        end
        CMD_COMPLETE: begin
          if (off < issued) begin
            val_mem[s] = it.completion_value;
            done_q[s]  = 1'b1;
          end
        end
        default: begin
          if (off < live && done_q[s]) begin
            r.value_out   = val_mem[s];
            consumed_q[s] = 1'b1;
            // retire the oldest slots that are done and consumed
            while (reclaim_p != alloc_p && done_q[reclaim_p[TagW-1:0]]
                   && consumed_q[reclaim_p[TagW-1:0]]) begin
              done_q[reclaim_p[TagW-1:0]]     = 1'b0;
              consumed_q[reclaim_p[TagW-1:0]] = 1'b0;
              reclaim_p++;
            end
          end else begin
            r.status = ST_NOT_DONE;
          end
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t exp_r;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: st=%0d tag=%0d arg=%h val=%h",
                   got.status, got.tag_out, got.arg_out, got.value_out);
        return;
      end
      exp_r = replies_due.pop_front();
      n_checked++;
      case (exp_r.status)
        ST_FULL:     n_full++;
        ST_EMPTY:    n_empty++;
        ST_NOT_DONE: n_not_done++;
        default:     ;
      endcase
      if (got.status != exp_r.status || got.tag_out != exp_r.tag_out ||
          got.arg_out != exp_r.arg_out || got.value_out != exp_r.value_out) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d tag=%0d arg=%h val=%h, got st=%0d tag=%0d arg=%h val=%h",
                   exp_r.status, exp_r.tag_out, exp_r.arg_out, exp_r.value_out,
                   got.status, got.tag_out, got.arg_out, got.value_out);
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  task_ring_shadow book = new();

  bit quiet_sender;
  int stall_left;
  int stall_mode;
  int cycle_cnt;

  task_tag_ring_in_order_reclaim dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check accepted items, stall in modes that change now and then
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_reply(out_item_o);
    cycle_cnt++;
    if (cycle_cnt % 250 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (stall_mode != 0 && $urandom_range(0, 99) < (stall_mode == 1 ? 15 : 45))
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  task automatic send_cmd(cmd_e c, bit [TagW-1:0] t, bit [DataW-1:0] a, bit [DataW-1:0] v);
    in_item_t it;
    int       gap;
    int       r;
    it.cmd              = c;
    it.tag              = t;
    it.task_arg         = a;
    it.completion_value = v;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    book.note_command(it);
    r   = $urandom_range(0, 99);
    gap = quiet_sender ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) :
          $urandom_range(4, 30);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (book.pending_count() != 0);
  endtask

  initial begin
    int   lim[3][3];
    int   mix;
    int   r;
    cmd_e c;
    bit [TagW-1:0] t;
    lim = '{'{30, 55, 80}, '{60, 75, 88}, '{10, 35, 65}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, unissued tags, overwrite, repeat consume, reclaim
    send_cmd(CMD_FETCH, 0, $urandom, $urandom);
    send_cmd(CMD_CONSUME, 0, $urandom, $urandom);
    send_cmd(CMD_COMPLETE, 0, $urandom, 32'hFFFF_FFFF);
    send_cmd(CMD_DISPATCH, 6'h3F, 32'h0, $urandom);
    send_cmd(CMD_DISPATCH, 6'h00, 32'hFFFF_FFFF, $urandom);
    send_cmd(CMD_DISPATCH, TagW'($urandom), $urandom, $urandom);
    send_cmd(CMD_COMPLETE, 1, $urandom, 32'h1234_5678);
    send_cmd(CMD_FETCH, 6'h3F, $urandom, $urandom);
    send_cmd(CMD_FETCH, 0, $urandom, $urandom);
    send_cmd(CMD_FETCH, 0, $urandom, $urandom);
    send_cmd(CMD_FETCH, 0, $urandom, $urandom);
    send_cmd(CMD_COMPLETE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_COMPLETE, 1, 32'h0, 32'h0);
    send_cmd(CMD_CONSUME, 1, $urandom, $urandom);
    send_cmd(CMD_CONSUME, 1, $urandom, $urandom);
    send_cmd(CMD_CONSUME, 0, $urandom, $urandom);
    send_cmd(CMD_COMPLETE, 0, $urandom, 32'hFFFF_FFFF);
    send_cmd(CMD_CONSUME, 0, $urandom, $urandom);
    send_cmd(CMD_CONSUME, 1, $urandom, $urandom);
    send_cmd(CMD_COMPLETE, 6'h3F, $urandom, $urandom);
    send_cmd(CMD_CONSUME, 6'h3F, $urandom, $urandom);
    drain_wait();

    // fill past capacity
    quiet_sender = 1'b1;
    repeat (Depth + 2) send_cmd(CMD_DISPATCH, TagW'($urandom), $urandom, $urandom);
    quiet_sender = 1'b0;
    drain_wait();

    // random mix: balanced, fill-heavy and drain-heavy stretches
    for (int n = 0; n < 1080; n++) begin
      if (n % 120 == 0) begin
        mix          = $urandom_range(0, 2);
        quiet_sender = ($urandom_range(0, 3) == 0);
      end
      if (n == 540) drain_wait();
      r = $urandom_range(0, 99);
      if (r < lim[mix][0])      c = CMD_DISPATCH;
      else if (r < lim[mix][1]) c = CMD_FETCH;
      else if (r < lim[mix][2]) c = CMD_COMPLETE;
      else                      c = CMD_CONSUME;
      if ($urandom_range(0, 99) < 15) t = TagW'($urandom);
      else                            t = book.pick_tag(c == CMD_CONSUME);
      send_cmd(c, t, $urandom, $urandom);
    end
    in_valid_i <= 1'b0;

    while (book.pending_count() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    book.errors += book.pending_count();
    $display("ran %0d commands, checked %0d replies", book.n_items, book.n_checked);
    $display("ring full %0d, empty fetch %0d, not done %0d, mismatches %0d",
             book.n_full, book.n_empty, book.n_not_done, book.errors);
    if (book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/core/ttr_pkg.sv
rtl/core/ttr_ram.sv
rtl/core/ttr_ctrl.sv
rtl/core/ttr_dp.sv
rtl/core/task_tag_ring_in_order_reclaim.sv
verif/tb.sv
